// File: src/lj_pkg.sv
// Lennard-Jones pair force: shared types, widths, stage numbers and constants.
// No dependencies; used by every module of the block.
package lj_pkg;

    localparam int AXES           = 3;
    localparam int DIMENSIONS_DEF = 3;

    localparam int POS_W   = 24;
    localparam int BOX_W   = 23;
    localparam int OUT_W   = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [BOX_W-1:0] BOX_RESET = 23'd655360;
    localparam logic             BOX_INDEX = 1'b0;

    // datapath widths
    localparam int T_W   = POS_W + 1;
    localparam int MAG_W = POS_W;
    localparam int D_W   = POS_W + 2;
    localparam int DM_W  = D_W - 1;
    localparam int SQ_W  = 2 * DM_W;
    localparam int S_W   = SQ_W + 2;
    localparam int U_W   = 33;
    localparam int U2_W  = 37;
    localparam int U3_W  = 41;
    localparam int U4_W  = 45;
    localparam int U6_W  = 53;
    localparam int U7_W  = 57;
    localparam int CM_W  = 62;
    localparam int FM_W  = 60;
    localparam int EM_W  = U6_W + 3;

    localparam int FRAC_SHIFT = 28;
    localparam int NUM_EXP    = 60;
    localparam int E_SHIFT    = 12;

    localparam logic [S_W-1:0] CLOSE_LIMIT = S_W'(64'd1 << FRAC_SHIFT);

    localparam logic signed [OUT_W-1:0] SAT_POS = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] SAT_NEG = 32'sh8000_0000;

    // stage numbers, counted in register layers after the accepting edge
    localparam int MUL_LAT   = 2;
    localparam int DIV_LAT   = U_W;
    localparam int STG_D     = 2;
    localparam int STG_SQ    = 3;
    localparam int STG_S     = 4;
    localparam int STG_U     = STG_S + DIV_LAT;
    localparam int STG_U2    = STG_U + MUL_LAT;
    localparam int STG_U34   = STG_U2 + MUL_LAT;
    localparam int STG_U6    = STG_U34 + MUL_LAT;
    localparam int STG_U7    = STG_U6 + MUL_LAT;
    localparam int STG_EM    = STG_U6 + 1;
    localparam int STG_EN    = STG_EM + 1;
    localparam int STG_C     = STG_U7 + 1;
    localparam int STG_FORCE = STG_C + MUL_LAT + 1;
    localparam int LATENCY   = STG_FORCE + 1;

    typedef struct packed {
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] first_z;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic signed [POS_W-1:0] second_z;
    } pos_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] force_x;
        logic signed [OUT_W-1:0] force_y;
        logic signed [OUT_W-1:0] force_z;
        logic signed [OUT_W-1:0] pair_energy;
        logic                    range_fault;
    } result_t;

    // coefficient side info handed to each lane
    typedef struct packed {
        logic close;
        logic cneg;
    } coef_ctl_t;

endpackage

// File: src/lennard_jones_pair_force.sv
// One transaction is accepted every cycle and busy is never asserted.
// Depth is set by the 33-stage divider forming 1/r^2 and the chain of
// rounded power multipliers behind it. Results are strobed for one cycle.
// Reset clears the valid pipeline and sets box_length to 10.0.
// Depends on lj_pkg, lj_mul, lj_div, lj_lane.
module lennard_jones_pair_force #(
    parameter int DIMENSIONS = lj_pkg::DIMENSIONS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lj_pkg::pos_t                  positions,
    output logic                          done,
    output lj_pkg::result_t               result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lj_pkg::PADDR_W-1:0]    paddr,
    input  logic [lj_pkg::PDATA_W-1:0]    pwdata,
    output logic [lj_pkg::PDATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int AXES      = lj_pkg::AXES;
    localparam int LATENCY   = lj_pkg::LATENCY;
    localparam int S_W       = lj_pkg::S_W;
    localparam int U_W       = lj_pkg::U_W;
    localparam int CM_W      = lj_pkg::CM_W;
    localparam int EM_W      = lj_pkg::EM_W;
    localparam int OUT_W     = lj_pkg::OUT_W;
    localparam int E_SHIFT_L = lj_pkg::E_SHIFT;
    localparam int CL_DLY    = lj_pkg::STG_FORCE - lj_pkg::STG_S;
    localparam int CL_C      = lj_pkg::STG_C - lj_pkg::STG_S - 1;
    localparam int U_DLY     = lj_pkg::STG_U6 - lj_pkg::STG_U;
    localparam int U_AT2     = lj_pkg::STG_U2 - lj_pkg::STG_U - 1;
    localparam int U3_DLY    = lj_pkg::STG_U6 - lj_pkg::STG_U34;
    localparam int U4_DLY    = lj_pkg::STG_U7 - lj_pkg::STG_U34;
    localparam int EN_DLY    = lj_pkg::STG_FORCE - lj_pkg::STG_EN + 1;

    logic [lj_pkg::BOX_W-1:0]  box_reg;
    logic                      cfg_write;
    logic [LATENCY-1:0]        vld_reg;

    logic signed [lj_pkg::POS_W-1:0] first_a  [AXES];
    logic signed [lj_pkg::POS_W-1:0] second_a [AXES];
    logic [lj_pkg::SQ_W-1:0]         sq       [AXES];
    logic signed [OUT_W-1:0]         force_v  [AXES];
    logic [AXES-1:0]                 lane_fault;

    logic [S_W-1:0]  s_next;
    logic [S_W-1:0]  s_reg;
    logic            close_reg;
    logic            close_dly_reg [CL_DLY];

    logic [U_W-1:0]          u;
    logic [U_W-1:0]          u_dly_reg  [U_DLY];
    logic [lj_pkg::U2_W-1:0] u2;
    logic [lj_pkg::U3_W-1:0] u3;
    logic [lj_pkg::U4_W-1:0] u4;
    logic [lj_pkg::U6_W-1:0] u6;
    logic [lj_pkg::U7_W-1:0] u7;
    logic [lj_pkg::U3_W-1:0] u3_dly_reg [U3_DLY];
    logic [lj_pkg::U4_W-1:0] u4_dly_reg [U4_DLY];

    logic [EM_W-1:0]         em_reg;
    logic                    eneg_reg;
    logic [EM_W-1:0]         em_round;
    logic [EM_W-E_SHIFT_L-1:0] er;
    logic signed [OUT_W-1:0] energy_next;
    logic                    efault_next;
    logic signed [OUT_W-1:0] energy_dly_reg [EN_DLY];
    logic                    efault_dly_reg [EN_DLY];

    logic [CM_W-1:0]   pos_term;
    logic [CM_W-1:0]   neg_term;
    logic [CM_W-1:0]   cm_reg;
    logic              cneg_reg;
    lj_pkg::coef_ctl_t coef_ctl;

    lj_pkg::result_t   result_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_reg <= lj_pkg::BOX_RESET;
        else if (cfg_write && paddr[lj_pkg::PADDR_W-1] == lj_pkg::BOX_INDEX)
            box_reg <= pwdata[lj_pkg::BOX_W-1:0];
    end

    assign prdata = (paddr[lj_pkg::PADDR_W-1] == lj_pkg::BOX_INDEX)
                  ? lj_pkg::PDATA_W'(box_reg) : '0;

    // ---------------- transaction valid pipeline ----------------
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-2:0], start && !busy};
    end

    // ---------------- lanes ----------------
    always_comb
    begin
        first_a[0]  = positions.first_x;
        first_a[1]  = positions.first_y;
        first_a[2]  = positions.first_z;
        second_a[0] = positions.second_x;
        second_a[1] = positions.second_y;
        second_a[2] = positions.second_z;
    end

    assign coef_ctl = '{close: close_dly_reg[CL_C], cneg: cneg_reg};

    for (genvar i = 0; i < AXES; i++)
    begin : g_axis
        if (i < DIMENSIONS)
        begin : g_lane
            lj_lane u_lane (
                .clk       (clk),
                .first     (first_a[i]),
                .second    (second_a[i]),
                .box       (box_reg),
                .coef_mag  (cm_reg),
                .ctl       (coef_ctl),
                .sq        (sq[i]),
                .force_val (force_v[i]),
                .fault     (lane_fault[i])
            );
        end
        else
        begin : g_unused
            assign sq[i]         = '0;
            assign force_v[i]    = '0;
            assign lane_fault[i] = 1'b0;
        end
    end

    // ---------------- r^2 and close-pair test ----------------
    always_comb
    begin
        s_next = '0;
        for (int k = 0; k < AXES; k++)
        begin
            s_next = s_next + S_W'(sq[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg            <= s_next;
        close_reg        <= (s_next <= lj_pkg::CLOSE_LIMIT);
        close_dly_reg[0] <= close_reg;
        for (int k = 1; k < CL_DLY; k++)
        begin
            close_dly_reg[k] <= close_dly_reg[k-1];
        end
    end

    // ---------------- u = 1/r^2 and its powers ----------------
    lj_div u_div (
        .clk (clk),
        .s   (s_reg),
        .q   (u)
    );

    always_ff @(posedge clk)
    begin
        u_dly_reg[0]  <= u;
        for (int k = 1; k < U_DLY; k++)
        begin
            u_dly_reg[k] <= u_dly_reg[k-1];
        end
        u3_dly_reg[0] <= u3;
        for (int k = 1; k < U3_DLY; k++)
        begin
            u3_dly_reg[k] <= u3_dly_reg[k-1];
        end
        u4_dly_reg[0] <= u4;
        for (int k = 1; k < U4_DLY; k++)
        begin
            u4_dly_reg[k] <= u4_dly_reg[k-1];
        end
    end

    lj_mul #(.WA(U_W), .WB(U_W), .WP(lj_pkg::U2_W)) u_mul_u2 (
        .clk (clk), .a (u), .b (u), .p (u2)
    );

    lj_mul #(.WA(lj_pkg::U2_W), .WB(U_W), .WP(lj_pkg::U3_W)) u_mul_u3 (
        .clk (clk), .a (u2), .b (u_dly_reg[U_AT2]), .p (u3)
    );

    lj_mul #(.WA(lj_pkg::U2_W), .WB(lj_pkg::U2_W), .WP(lj_pkg::U4_W)) u_mul_u4 (
        .clk (clk), .a (u2), .b (u2), .p (u4)
    );

    lj_mul #(.WA(lj_pkg::U3_W), .WB(lj_pkg::U3_W), .WP(lj_pkg::U6_W)) u_mul_u6 (
        .clk (clk), .a (u3), .b (u3), .p (u6)
    );

    lj_mul #(.WA(lj_pkg::U6_W), .WB(U_W), .WP(lj_pkg::U7_W)) u_mul_u7 (
        .clk (clk), .a (u6), .b (u_dly_reg[U_DLY-1]), .p (u7)
    );

    // ---------------- energy 4*(u6 - u3) ----------------
    always_ff @(posedge clk)
    begin
        if (u6 >= lj_pkg::U6_W'(u3_dly_reg[U3_DLY-1]))
            em_reg <= (EM_W'(u6) - EM_W'(u3_dly_reg[U3_DLY-1])) << 2;
        else
            em_reg <= (EM_W'(u3_dly_reg[U3_DLY-1]) - EM_W'(u6)) << 2;
        eneg_reg <= u6 < lj_pkg::U6_W'(u3_dly_reg[U3_DLY-1]);
    end

    assign em_round = em_reg + (EM_W'(1) << (E_SHIFT_L - 1));
    assign er       = em_round[EM_W-1:E_SHIFT_L];

    always_comb
    begin
        energy_next = '0;
        efault_next = 1'b0;
        if (eneg_reg && er != '0)
        begin
            if (er > ((EM_W-E_SHIFT_L)'(1) << (OUT_W - 1)))
            begin
                efault_next = 1'b1;
                energy_next = lj_pkg::SAT_NEG;
            end
            else
            begin
                energy_next = -OUT_W'(er);
            end
        end
        else if (er > (EM_W-E_SHIFT_L)'(lj_pkg::SAT_POS))
        begin
            efault_next = 1'b1;
            energy_next = lj_pkg::SAT_POS;
        end
        else
        begin
            energy_next = OUT_W'(er);
        end
    end

    always_ff @(posedge clk)
    begin
        energy_dly_reg[0] <= energy_next;
        efault_dly_reg[0] <= efault_next;
        for (int k = 1; k < EN_DLY; k++)
        begin
            energy_dly_reg[k] <= energy_dly_reg[k-1];
            efault_dly_reg[k] <= efault_dly_reg[k-1];
        end
    end

    // ---------------- force coefficient 48*u7 - 24*u4 ----------------
    assign pos_term = (CM_W'(u7) << 5) + (CM_W'(u7) << 4);
    assign neg_term = (CM_W'(u4_dly_reg[U4_DLY-1]) << 4)
                    + (CM_W'(u4_dly_reg[U4_DLY-1]) << 3);

    always_ff @(posedge clk)
    begin
        cneg_reg <= pos_term < neg_term;
        cm_reg   <= (pos_term < neg_term) ? (neg_term - pos_term) : (pos_term - neg_term);
    end

    // ---------------- merge ----------------
    always_ff @(posedge clk)
    begin
        result_reg.force_x     <= force_v[0];
        result_reg.force_y     <= force_v[1];
        result_reg.force_z     <= force_v[2];
        result_reg.pair_energy <= close_dly_reg[CL_DLY-1] ? lj_pkg::SAT_POS
                                                          : energy_dly_reg[EN_DLY-1];
        result_reg.range_fault <= close_dly_reg[CL_DLY-1] || efault_dly_reg[EN_DLY-1]
                                  || (|lane_fault);
    end

    assign done   = vld_reg[LATENCY-1];
    assign result = result_reg;

endmodule

// File: src/lj_mul.sv
// Two-stage unsigned multiplier with Q.28 rounding: 32x32 partial products,
// then sum, round and shift. Depends on lj_pkg.
module lj_mul #(
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int WP = 32
) (
    input  logic          clk,
    input  logic [WA-1:0] a,
    input  logic [WB-1:0] b,
    output logic [WP-1:0] p
);

    localparam int HALF  = 32;
    localparam int FULL  = 2 * HALF;
    localparam int WIDE  = 4 * HALF;
    localparam int SHIFT = lj_pkg::FRAC_SHIFT;

    logic [FULL-1:0] a_ext;
    logic [FULL-1:0] b_ext;
    logic [FULL-1:0] pp_reg [4];
    logic [WIDE-1:0] sum;
    logic [WP-1:0]   p_reg;

    assign a_ext = FULL'(a);
    assign b_ext = FULL'(b);

    always_ff @(posedge clk)
    begin
        pp_reg[0] <= a_ext[HALF-1:0]    * b_ext[HALF-1:0];
        pp_reg[1] <= a_ext[HALF-1:0]    * b_ext[FULL-1:HALF];
        pp_reg[2] <= a_ext[FULL-1:HALF] * b_ext[HALF-1:0];
        pp_reg[3] <= a_ext[FULL-1:HALF] * b_ext[FULL-1:HALF];
    end

    assign sum = WIDE'(pp_reg[0])
               + (WIDE'(pp_reg[1]) << HALF)
               + (WIDE'(pp_reg[2]) << HALF)
               + (WIDE'(pp_reg[3]) << FULL)
               + (WIDE'(1) << (SHIFT - 1));

    always_ff @(posedge clk)
    begin
        p_reg <= sum[SHIFT +: WP];
    end

    assign p = p_reg;

endmodule

// File: src/lj_div.sv
// Pipelined restoring divider: u = round(2^60 / s), one quotient bit per stage.
// Depends on lj_pkg.
module lj_div (
    input  logic                     clk,
    input  logic [lj_pkg::S_W-1:0]   s,
    output logic [lj_pkg::U_W-1:0]   q
);

    localparam int SW     = lj_pkg::S_W;
    localparam int QW     = lj_pkg::U_W;
    localparam int STAGES = lj_pkg::DIV_LAT;

    logic [SW-1:0] rem_reg [STAGES-1];
    logic [SW-1:0] div_reg [STAGES-1];
    logic [QW-1:0] quo_reg [STAGES];

    // dividend is 2^60 + s/2: its low QW bits are s[QW:1]
    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        localparam int K = STAGES - 1 - j;
        logic [SW-1:0] rem_in;
        logic [SW-1:0] div_in;
        logic [QW-1:0] quo_in;
        logic [SW:0]   trial;
        logic [SW:0]   diff;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign rem_in = (SW'(1) << (lj_pkg::NUM_EXP - QW)) + SW'(s >> (QW + 1));
            assign div_in = s;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign div_in = div_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign trial = {rem_in, div_in[K+1]};
        assign ge    = trial >= {1'b0, div_in};
        assign diff  = trial - {1'b0, div_in};

        always_ff @(posedge clk)
        begin
            quo_reg[j] <= quo_in | (ge ? (QW'(1) << K) : '0);
        end

        if (j < STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[j] <= ge ? diff[SW-1:0] : trial[SW-1:0];
                div_reg[j] <= div_in;
            end
        end
    end

    assign q = quo_reg[STAGES-1];

endmodule

// File: src/lj_lane.sv
// One axis lane: minimum-image displacement, its square, and the force
// component from the shared coefficient. Depends on lj_pkg, lj_mul.
module lj_lane (
    input  logic                               clk,
    input  logic signed [lj_pkg::POS_W-1:0]    first,
    input  logic signed [lj_pkg::POS_W-1:0]    second,
    input  logic [lj_pkg::BOX_W-1:0]           box,
    input  logic [lj_pkg::CM_W-1:0]            coef_mag,
    input  lj_pkg::coef_ctl_t                  ctl,
    output logic [lj_pkg::SQ_W-1:0]            sq,
    output logic signed [lj_pkg::OUT_W-1:0]    force_val,
    output logic                               fault
);

    localparam int T_W   = lj_pkg::T_W;
    localparam int MAG_W = lj_pkg::MAG_W;
    localparam int D_W   = lj_pkg::D_W;
    localparam int DM_W  = lj_pkg::DM_W;
    localparam int FM_W  = lj_pkg::FM_W;
    localparam int OUT_W = lj_pkg::OUT_W;
    localparam int D_DLY = lj_pkg::STG_C - lj_pkg::STG_D;

    typedef struct packed {
        logic close;
        logic cneg;
        logic dneg;
        logic dzero;
    } side_t;

    logic signed [T_W-1:0]   diff_ab;
    logic signed [T_W-1:0]   diff_ba;
    logic signed [T_W-1:0]   t_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    fold;
    logic signed [D_W-1:0]   t_ext;
    logic signed [D_W-1:0]   box_ext;
    logic signed [D_W-1:0]   d_next;
    logic signed [D_W-1:0]   d_reg;
    logic [DM_W-1:0]         dabs;
    logic [lj_pkg::SQ_W-1:0] sq_reg;
    logic signed [D_W-1:0]   d_dly_reg [D_DLY];
    logic signed [D_W-1:0]   d_late;
    logic [DM_W-1:0]         dm_late;
    side_t                   side_reg [lj_pkg::MUL_LAT];
    side_t                   side;
    logic [FM_W-1:0]         fm;
    logic                    neg;
    logic signed [OUT_W-1:0] force_next;
    logic                    fault_next;
    logic signed [OUT_W-1:0] force_reg;
    logic                    fault_reg;

    // stage 1: difference and its magnitude
    assign diff_ab = T_W'(first) - T_W'(second);
    assign diff_ba = T_W'(second) - T_W'(first);

    always_ff @(posedge clk)
    begin
        t_reg   <= diff_ab;
        mag_reg <= diff_ab[T_W-1] ? diff_ba[MAG_W-1:0] : diff_ab[MAG_W-1:0];
    end

    // stage 2: minimum image, one box toward zero
    assign fold    = {mag_reg, 1'b0} >= {2'b00, box};
    assign t_ext   = D_W'(t_reg);
    assign box_ext = D_W'(box);

    always_comb
    begin
        if (!fold)
            d_next = t_ext;
        else if (!t_reg[T_W-1] && t_reg != '0)
            d_next = t_ext - box_ext;
        else
            d_next = t_ext + box_ext;
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    // stage 3: square of the magnitude
    assign dabs = d_reg[D_W-1] ? DM_W'(-d_reg) : DM_W'(d_reg);

    always_ff @(posedge clk)
    begin
        sq_reg       <= dabs * dabs;
        d_dly_reg[0] <= d_reg;
        for (int k = 1; k < D_DLY; k++)
        begin
            d_dly_reg[k] <= d_dly_reg[k-1];
        end
    end

    assign sq = sq_reg;

    // coefficient stage: |c| * |d|
    assign d_late  = d_dly_reg[D_DLY-1];
    assign dm_late = d_late[D_W-1] ? DM_W'(-d_late) : DM_W'(d_late);

    lj_mul #(
        .WA (lj_pkg::CM_W),
        .WB (DM_W),
        .WP (FM_W)
    ) u_force_mul (
        .clk (clk),
        .a   (coef_mag),
        .b   (dm_late),
        .p   (fm)
    );

    always_ff @(posedge clk)
    begin
        side_reg[0] <= '{close: ctl.close, cneg: ctl.cneg,
                         dneg: d_late[D_W-1], dzero: (d_late == '0)};
        for (int k = 1; k < lj_pkg::MUL_LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign side = side_reg[lj_pkg::MUL_LAT-1];
    assign neg  = (side.cneg == side.dneg) && (fm != '0);

    // sign and saturation
    always_comb
    begin
        force_next = '0;
        fault_next = 1'b0;
        if (side.close)
        begin
            fault_next = 1'b1;
            if (side.dzero)
                force_next = '0;
            else
                force_next = side.dneg ? lj_pkg::SAT_POS : lj_pkg::SAT_NEG;
        end
        else if (neg)
        begin
            if (fm > (FM_W'(1) << (OUT_W - 1)))
            begin
                fault_next = 1'b1;
                force_next = lj_pkg::SAT_NEG;
            end
            else
            begin
                force_next = -OUT_W'(fm);
            end
        end
        else
        begin
            if (fm > FM_W'(lj_pkg::SAT_POS))
            begin
                fault_next = 1'b1;
                force_next = lj_pkg::SAT_POS;
            end
            else
            begin
                force_next = OUT_W'(fm);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        force_reg <= force_next;
        fault_reg <= fault_next;
    end

    assign force_val = force_reg;
    assign fault     = fault_reg;

endmodule

// File: src/lj_checker.sv
// Port-level checks for lennard_jones_pair_force and the bind that attaches them.
// Depends on lj_pkg and the top level's ports.
module lj_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input lj_pkg::pos_t                  positions,
    input logic                          done,
    input lj_pkg::result_t               result,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [lj_pkg::PADDR_W-1:0]    paddr,
    input logic [lj_pkg::PDATA_W-1:0]    pwdata,
    input logic [lj_pkg::PDATA_W-1:0]    prdata,
    input logic                          pready
);

    // every accepted transaction comes back after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(lj_pkg::LATENCY) done)
        else $error("accepted transaction produced no result");

    // no result without a transaction accepted one latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, lj_pkg::LATENCY))
        else $error("result strobe without matching transaction");

    // box register reads back what was written
    a_box_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[lj_pkg::PADDR_W-1] == 1'b0)
        |=> (paddr[lj_pkg::PADDR_W-1] != 1'b0
             || prdata[lj_pkg::BOX_W-1:0] == $past(pwdata[lj_pkg::BOX_W-1:0])))
        else $error("box_length readback mismatch");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind lennard_jones_pair_force lj_checker u_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lennard_jones_pair_force: directed table, then random
// pairs under several box lengths, with results checked against a fixed-point predictor.
// Depends on lj_pkg and the lennard_jones_pair_force RTL.
module testbench;

    localparam int  IDLE_LIMIT = 5000;
    localparam int  PER_PHASE  = 62;
    localparam logic [lj_pkg::PADDR_W-1:0] BOX_ADDR =
        lj_pkg::PADDR_W'(4 * lj_pkg::BOX_INDEX);
    localparam logic signed [lj_pkg::POS_W-1:0] ONE = 24'sd65536;

    typedef struct {
        lj_pkg::pos_t    pos;
        bit              known;
        lj_pkg::result_t res;
    } row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    lj_pkg::pos_t               positions;
    logic                       done;
    lj_pkg::result_t            result;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [lj_pkg::PADDR_W-1:0] paddr;
    logic [lj_pkg::PDATA_W-1:0] pwdata;
    logic [lj_pkg::PDATA_W-1:0] prdata;
    logic                       pready;

    logic [lj_pkg::BOX_W-1:0] box_copy;
    lj_pkg::result_t          pending_results[$];
    bit                       failed;
    int                       idle_cycles;

    lennard_jones_pair_force dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .positions(positions),
        .done     (done),
        .result   (result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // exact product, rounded to Q.28; saturates like a 64-bit unsigned
    function automatic longint unsigned mul_round28(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = 128'(a) * 128'(b) + (128'd1 << 27);
        p = p >> 28;
        if (p[127:64] != 0)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        return p[63:0];
    endfunction

    function automatic logic [lj_pkg::OUT_W-1:0] clamp32(longint unsigned mag, bit neg,
                                                         inout bit fault);
        if (neg)
        begin
            if (mag > 64'd2147483648)
            begin
                fault = 1'b1;
                return lj_pkg::SAT_NEG;
            end
            return lj_pkg::OUT_W'(-longint'(mag));
        end
        if (mag > 64'd2147483647)
        begin
            fault = 1'b1;
            return lj_pkg::SAT_POS;
        end
        return lj_pkg::OUT_W'(mag);
    endfunction

    function automatic lj_pkg::result_t pair_force(lj_pkg::pos_t p,
                                                   logic [lj_pkg::BOX_W-1:0] box);
        longint          a[lj_pkg::AXES];
        longint          b[lj_pkg::AXES];
        longint          d[lj_pkg::AXES];
        longint          t;
        longint          c;
        longint          e;
        longint unsigned mag, s, u, u2, u3, u4, u6, u7, cm, em, dm, fm;
        logic [lj_pkg::OUT_W-1:0] f[lj_pkg::AXES];
        logic [lj_pkg::OUT_W-1:0] en;
        bit              fault;
        bit              neg;
        lj_pkg::result_t r;
        a[0] = p.first_x;  a[1] = p.first_y;  a[2] = p.first_z;
        b[0] = p.second_x; b[1] = p.second_y; b[2] = p.second_z;
        s = 0;
        fault = 1'b0;
        for (int i = 0; i < lj_pkg::AXES; i++)
        begin
            t = a[i] - b[i];
            mag = (t < 0) ? -t : t;
            if (!(2 * mag < box))
                t = (t > 0) ? t - longint'(box) : t + longint'(box);
            d[i] = t;
            mag = (t < 0) ? -t : t;
            s += mag * mag;
        end
        if (s <= (64'd1 << 28))
        begin
            fault = 1'b1;
            en = lj_pkg::SAT_POS;
            for (int i = 0; i < lj_pkg::AXES; i++)
                f[i] = (d[i] == 0) ? '0 : ((d[i] > 0) ? lj_pkg::SAT_NEG : lj_pkg::SAT_POS);
        end
        else
        begin
            u  = ((64'd1 << 60) + s / 2) / s;
            u2 = mul_round28(u, u);
            u3 = mul_round28(u2, u);
            u4 = mul_round28(u2, u2);
            u6 = mul_round28(u3, u3);
            u7 = mul_round28(u6, u);
            c  = 48 * longint'(u7) - 24 * longint'(u4);
            e  = 4 * (longint'(u6) - longint'(u3));
            cm = (c < 0) ? -c : c;
            em = (e < 0) ? -e : e;
            for (int i = 0; i < lj_pkg::AXES; i++)
            begin
                dm  = (d[i] < 0) ? -d[i] : d[i];
                fm  = mul_round28(cm, dm);
                neg = ((c < 0) == (d[i] < 0)) && (fm != 0);
                f[i] = clamp32(fm, neg, fault);
            end
            em = (em + (64'd1 << 11)) >> 12;
            en = clamp32(em, (e < 0) && (em != 0), fault);
        end
        r.force_x     = f[0];
        r.force_y     = f[1];
        r.force_z     = f[2];
        r.pair_energy = en;
        r.range_fault = fault;
        return r;
    endfunction

    function automatic lj_pkg::pos_t make_pos(int fx, int fy, int fz, int sx, int sy, int sz);
        lj_pkg::pos_t p;
        p.first_x  = lj_pkg::POS_W'(fx);
        p.first_y  = lj_pkg::POS_W'(fy);
        p.first_z  = lj_pkg::POS_W'(fz);
        p.second_x = lj_pkg::POS_W'(sx);
        p.second_y = lj_pkg::POS_W'(sy);
        p.second_z = lj_pkg::POS_W'(sz);
        return p;
    endfunction

    // offset of second from first on one axis, chosen by pair kind
    function automatic int axis_offset(int kind, logic [lj_pkg::BOX_W-1:0] box);
        case (kind)
            0:       return $urandom_range(0, 3 * 65536) - 3 * 32768;
            1:       return int'(box) - $urandom_range(0, 2 * 65536) + 65536;
            default: return $urandom_range(0, 32768) - 16384;
        endcase
    endfunction

    function automatic lj_pkg::pos_t random_pair(logic [lj_pkg::BOX_W-1:0] box);
        int   sel;
        int   kind;
        int   fst[lj_pkg::AXES];
        int   snd[lj_pkg::AXES];
        sel = $urandom_range(0, 9);
        kind = (sel < 5) ? 0 : ((sel < 8) ? 1 : 2);
        for (int i = 0; i < lj_pkg::AXES; i++)
        begin
            fst[i] = $urandom;
            if (sel < 2)
                snd[i] = $urandom;
            else if (sel == 9 && $urandom_range(0, 1))
                snd[i] = fst[i];
            else
                snd[i] = fst[i] - axis_offset(kind, box);
        end
        return make_pos(fst[0], fst[1], fst[2], snd[0], snd[1], snd[2]);
    endfunction

    function automatic int pick_gap(bit dense);
        int r;
        r = $urandom_range(0, 99);
        if (dense || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pair(lj_pkg::pos_t p, int gap);
        @(negedge clk);
        positions = p;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop sending, then wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (lj_pkg::LATENCY + 4) @(posedge clk);
    endtask

    task automatic apb_access(bit wr, logic [lj_pkg::PDATA_W-1:0] data);
        @(negedge clk);
        start   = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = BOX_ADDR;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        if (wr)
            box_copy = data[lj_pkg::BOX_W-1:0];
        else if (prdata != lj_pkg::PDATA_W'(box_copy))
        begin
            $error("box_length readback: expected %0d, got %0d", box_copy, prdata);
            failed = 1'b1;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_box(logic [lj_pkg::BOX_W-1:0] value);
        drain_results();
        apb_access(1'b1, lj_pkg::PDATA_W'(value));
        apb_access(1'b0, '0);
    endtask

    // predict on every accepted transaction, check every strobed result
    always @(posedge clk)
    begin
        lj_pkg::result_t want;
        if (rst_n)
        begin
            if (start && !busy)
                pending_results = {pending_results, pair_force(positions, box_copy)};
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result strobed with no transaction outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.force_x !== want.force_x)
                    begin
                        $error("force_x: expected %0d, got %0d", want.force_x, result.force_x);
                        failed = 1'b1;
                    end
                    if (result.force_y !== want.force_y)
                    begin
                        $error("force_y: expected %0d, got %0d", want.force_y, result.force_y);
                        failed = 1'b1;
                    end
                    if (result.force_z !== want.force_z)
                    begin
                        $error("force_z: expected %0d, got %0d", want.force_z, result.force_z);
                        failed = 1'b1;
                    end
                    if (result.pair_energy !== want.pair_energy)
                    begin
                        $error("pair_energy: expected %0d, got %0d",
                               want.pair_energy, result.pair_energy);
                        failed = 1'b1;
                    end
                    if (result.range_fault !== want.range_fault)
                    begin
                        $error("range_fault: expected %0b, got %0b",
                               want.range_fault, result.range_fault);
                        failed = 1'b1;
                    end
                end
            end
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        row_t                     rows[$];
        row_t                     row;
        logic [lj_pkg::BOX_W-1:0] boxes[6];
        bit                       dense;
        rst_n       = 1'b0;
        start       = 1'b0;
        positions   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        failed      = 1'b0;
        box_copy    = lj_pkg::BOX_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // coincident pair: no force, energy and fault pinned
        row.known = 1'b1;
        row.pos = make_pos(0, 0, 0, 0, 0, 0);
        row.res = '{force_x: '0, force_y: '0, force_z: '0,
                    pair_energy: lj_pkg::SAT_POS, range_fault: 1'b1};
        rows = {rows, row};
        // at the close limit, positive x displacement
        row.pos = make_pos(16384, 0, 0, 0, 0, 0);
        row.res = '{force_x: lj_pkg::SAT_NEG, force_y: '0, force_z: '0,
                    pair_energy: lj_pkg::SAT_POS, range_fault: 1'b1};
        rows = {rows, row};
        // at the close limit, negative y displacement
        row.pos = make_pos(0, 0, 0, 0, 16384, 0);
        row.res = '{force_x: '0, force_y: lj_pkg::SAT_POS, force_z: '0,
                    pair_energy: lj_pkg::SAT_POS, range_fault: 1'b1};
        rows = {rows, row};
        row.known = 1'b0;
        row.res = '0;
        row.pos = make_pos(16385, 0, 0, 0, 0, 0);            rows = {rows, row};
        row.pos = make_pos(ONE, 0, 0, 0, 0, 0);              rows = {rows, row};
        row.pos = make_pos(0, 0, 73543, 0, 0, 0);            rows = {rows, row};
        row.pos = make_pos(0, 0, 0, 0, 0, 3 * ONE);          rows = {rows, row};
        row.pos = make_pos(5 * ONE, 0, 0, 0, 0, 0);          rows = {rows, row};
        row.pos = make_pos(5 * ONE - 1, 0, 0, 0, 0, 0);      rows = {rows, row};
        row.pos = make_pos(0, -5 * ONE, 0, 0, 0, 0);         rows = {rows, row};
        row.pos = make_pos(8388607, 8388607, 8388607,
                           -8388608, -8388608, -8388608);    rows = {rows, row};
        row.pos = make_pos(-8388608, -8388608, -8388608,
                           8388607, 8388607, 8388607);       rows = {rows, row};
        row.pos = make_pos(8388607, -8388608, 0,
                           8388607, 8388607, -8388608);      rows = {rows, row};
        row.pos = make_pos(ONE, ONE, ONE, -ONE, -ONE, -ONE); rows = {rows, row};
        row.pos = make_pos(-ONE, 2 * ONE, -3 * ONE, 0, 0, 0); rows = {rows, row};
        row.pos = make_pos(4 * ONE + 12345, -4 * ONE, 0,
                           -5 * ONE, 5 * ONE, 0);            rows = {rows, row};

        foreach (rows[i])
        begin
            send_pair(rows[i].pos, pick_gap(1'b0));
            if (rows[i].known && pair_force(rows[i].pos, box_copy) != rows[i].res)
            begin
                $error("directed row %0d: predictor disagrees with table", i);
                failed = 1'b1;
            end
        end

        boxes[0] = 23'd65536;
        boxes[1] = 23'd8388607;
        boxes[2] = '0;
        boxes[3] = lj_pkg::BOX_W'($urandom_range(65536, 8388607));
        boxes[4] = 23'd196608;
        boxes[5] = lj_pkg::BOX_RESET;
        for (int ph = -1; ph < 6; ph++)
        begin
            if (ph >= 0)
                set_box(boxes[ph]);
            dense = (ph == 1 || ph == 4);
            for (int n = 0; n < PER_PHASE; n++)
            begin
                send_pair(random_pair(box_copy), pick_gap(dense));
                // let the pipeline empty once mid-phase
                if (ph == 3 && n == PER_PHASE / 2)
                    drain_results();
            end
        end

        drain_results();
        if (!failed && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
